/* design/slseq_pkg.sv */
// Shared types, codes and constants for the stow lock sequencer.
package slseq_pkg;

  localparam int TickWidth    = 10;
  localparam int TimeoutWidth = 16;
  localparam int ElapsedWidth = 17;
  localparam int StatusWidth  = 4;
  localparam int CfgAddrWidth = 4;
  localparam int CfgDataWidth = 32;

  localparam logic [TickWidth-1:0]    TickPeriodReset = TickWidth'(10);
  localparam logic [TimeoutWidth-1:0] TimeoutReset    = TimeoutWidth'(5000);
  localparam logic                    AxisElevReset   = 1'b0;

  // Register indexes (word address paddr[3:2])
  localparam logic [1:0] REG_TICK_PERIOD = 2'd0;
  localparam logic [1:0] REG_TIMEOUT     = 2'd1;
  localparam logic [1:0] REG_AXIS_ELEV   = 2'd2;

  // Item opcodes
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_LOCK   = 2'd1;
  localparam logic [1:0] OP_UNLOCK = 2'd2;

  // Sequencer phases
  localparam logic [2:0] PH_IDLE        = 3'd0;
  localparam logic [2:0] PH_LOCK_INIT   = 3'd1;
  localparam logic [2:0] PH_LOCKING     = 3'd2;
  localparam logic [2:0] PH_LOCK_DONE   = 3'd3;
  localparam logic [2:0] PH_UNLOCK_INIT = 3'd4;
  localparam logic [2:0] PH_UNLOCKING   = 3'd5;
  localparam logic [2:0] PH_UNLOCK_DONE = 3'd6;
  localparam logic [2:0] PH_FAIL        = 3'd7;

  // Pending requests
  localparam logic [1:0] REQ_NONE   = 2'd0;
  localparam logic [1:0] REQ_LOCK   = 2'd1;
  localparam logic [1:0] REQ_UNLOCK = 2'd2;

  // Status kinds, azimuth numbering
  localparam logic [StatusWidth-1:0] ST_NONE       = 4'd0;
  localparam logic [StatusWidth-1:0] ST_LOCKBUSY   = 4'd1;
  localparam logic [StatusWidth-1:0] ST_LOCKED     = 4'd2;
  localparam logic [StatusWidth-1:0] ST_UNLOCKBUSY = 4'd3;
  localparam logic [StatusWidth-1:0] ST_UNLOCKED   = 4'd4;
  localparam logic [StatusWidth-1:0] ST_ERROR      = 4'd5;
  localparam logic [StatusWidth-1:0] ElevOffset    = 4'd5;

  localparam logic [ElapsedWidth-1:0] ElapsedMax = {ElapsedWidth{1'b1}};

  typedef struct packed {
    logic [TickWidth-1:0]    tick_period_ms;
    logic [TimeoutWidth-1:0] time_limit_ms;
    logic                    axis_is_elevation;
  } cfg_t;

  typedef struct packed {
    logic                   busy_res;
    logic                   fail_pulse;
    logic                   done_pulse;
    logic [StatusWidth-1:0] status_code;
    logic                   unlock_drive;
    logic                   lock_drive;
  } result_t;

  localparam int ResultWidth = $bits(result_t);

endpackage

/* design/slseq_cfg.sv */
// APB register file holding tick period, timeout and axis select.
module slseq_cfg
  import slseq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CfgAddrWidth-1:0] paddr,
  input  logic [CfgDataWidth-1:0] pwdata,
  output logic [CfgDataWidth-1:0] prdata,
  output logic                    pready,
  output cfg_t                    cfg
);

  logic wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tick_period_ms    <= TickPeriodReset;
      cfg.time_limit_ms     <= TimeoutReset;
      cfg.axis_is_elevation <= AxisElevReset;
    end else if (wr_en) begin
      case (reg_idx)
        REG_TICK_PERIOD: cfg.tick_period_ms    <= pwdata[TickWidth-1:0];
        REG_TIMEOUT:     cfg.time_limit_ms     <= pwdata[TimeoutWidth-1:0];
        REG_AXIS_ELEV:   cfg.axis_is_elevation <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TICK_PERIOD: prdata = CfgDataWidth'(cfg.tick_period_ms);
      REG_TIMEOUT:     prdata = CfgDataWidth'(cfg.time_limit_ms);
      REG_AXIS_ELEV:   prdata = CfgDataWidth'(cfg.axis_is_elevation);
      default:         prdata = '0;
    endcase
  end

endmodule

/* design/slseq_fsm.sv */
// Sequencer state and the per-item next-state and result logic.
module slseq_fsm
  import slseq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [1:0] opcode,
  input  logic       lock_sensor,
  input  logic       unlock_sensor,
  input  cfg_t       cfg,
  output result_t    res
);

  logic [2:0]              phase, phase_next;
  logic [1:0]              pending, pending_next;
  logic [ElapsedWidth-1:0] elapsed_ms, elapsed_next;
  logic [StatusWidth-1:0]  status_reg, status_next;
  logic                    lock_drv, lock_drv_next;
  logic                    unlock_drv, unlock_drv_next;
  logic                    done, fail;
  logic                    is_lock, target;
  logic [ElapsedWidth:0]   time_sum;
  logic [ElapsedWidth-1:0] time_sat;
  logic [StatusWidth-1:0]  base;

  assign base     = cfg.axis_is_elevation ? ElevOffset : ST_NONE;
  assign time_sum = {1'b0, elapsed_ms} + (ElapsedWidth+1)'(cfg.tick_period_ms);
  assign time_sat = time_sum[ElapsedWidth] ? ElapsedMax : time_sum[ElapsedWidth-1:0];
  assign is_lock  = (phase == PH_LOCK_INIT) || (phase == PH_LOCKING);
  assign target   = is_lock ? lock_sensor : unlock_sensor;

  always_comb begin
    phase_next      = phase;
    pending_next    = pending;
    elapsed_next    = elapsed_ms;
    status_next     = status_reg;
    lock_drv_next   = lock_drv;
    unlock_drv_next = unlock_drv;
    done            = 1'b0;
    fail            = 1'b0;
    case (opcode)
      OP_LOCK, OP_UNLOCK: begin
        // requests only land while idle; a later one replaces an earlier one
        if (phase == PH_IDLE) begin
          pending_next = (opcode == OP_LOCK) ? REQ_LOCK : REQ_UNLOCK;
        end
      end
      OP_TICK: begin
        case (phase)
          PH_IDLE: begin
            if (pending == REQ_LOCK) begin
              phase_next  = PH_LOCK_INIT;
              status_next = base + ST_LOCKBUSY;
            end else if (pending == REQ_UNLOCK) begin
              phase_next  = PH_UNLOCK_INIT;
              status_next = base + ST_UNLOCKBUSY;
            end
            pending_next = REQ_NONE;
          end
          PH_LOCK_INIT, PH_UNLOCK_INIT: begin
            if (lock_sensor && unlock_sensor) begin
              status_next = base + ST_ERROR;
              phase_next  = PH_FAIL;
            end else if (target) begin
              status_next = base + (is_lock ? ST_LOCKED : ST_UNLOCKED);
              phase_next  = is_lock ? PH_LOCK_DONE : PH_UNLOCK_DONE;
            end else begin
              lock_drv_next   = is_lock;
              unlock_drv_next = !is_lock;
              elapsed_next    = '0;
              status_next     = base + (is_lock ? ST_LOCKBUSY : ST_UNLOCKBUSY);
              phase_next      = is_lock ? PH_LOCKING : PH_UNLOCKING;
            end
          end
          PH_LOCKING, PH_UNLOCKING: begin
            elapsed_next = time_sat;
            if (target) begin
              lock_drv_next   = 1'b0;
              unlock_drv_next = 1'b0;
              status_next     = base + (is_lock ? ST_LOCKED : ST_UNLOCKED);
              phase_next      = is_lock ? PH_LOCK_DONE : PH_UNLOCK_DONE;
            end else if (time_sat > ElapsedWidth'(cfg.time_limit_ms)) begin
              lock_drv_next   = 1'b0;
              unlock_drv_next = 1'b0;
              status_next     = base + ST_ERROR;
              phase_next      = PH_FAIL;
            end
          end
          PH_LOCK_DONE, PH_UNLOCK_DONE: begin
            done       = 1'b1;
            phase_next = PH_IDLE;
          end
          default: begin
            fail       = 1'b1;
            phase_next = PH_IDLE;
          end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      pending    <= REQ_NONE;
      elapsed_ms <= '0;
      status_reg <= ST_NONE;
      lock_drv   <= 1'b0;
      unlock_drv <= 1'b0;
    end else if (step) begin
      phase      <= phase_next;
      pending    <= pending_next;
      elapsed_ms <= elapsed_next;
      status_reg <= status_next;
      lock_drv   <= lock_drv_next;
      unlock_drv <= unlock_drv_next;
    end
  end

  always_comb begin
    res.lock_drive   = lock_drv_next;
    res.unlock_drive = unlock_drv_next;
    res.status_code  = status_next;
    res.done_pulse   = done;
    res.fail_pulse   = fail;
    res.busy_res     = (phase_next != PH_IDLE);
  end

endmodule

/* design/stow_lock_sequencer_core.sv */
// Top level: input register, sequencer, result register and APB registers.
//
//   port group     dir  carries
//   s_axis_*       in   items: tuser opcode, tdata sensors
//   m_axis_*       out  results: drives, status, pulses, busy
//   APB            in   tick period, timeout, axis select
//
// An item is registered on entry, updates the sequencer state as it moves into
// the result register, and shows on m_axis from there: one item per cycle while
// m_axis_tready is high. The input register holds while the result register is
// full and stalled; only then, with both registers full, does s_axis_tready fall.
// Synchronous reset returns the sequencer to idle and the registers to defaults.
module stow_lock_sequencer_core
  import slseq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [7:0]              s_axis_tdata,   // [0] lock_sensor, [1] unlock_sensor
  input  logic [1:0]              s_axis_tuser,   // [1:0] opcode
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // [0] lock_drive, [1] unlock_drive, [5:2] status_code, [6] done_pulse,
  // [7] fail_pulse, [8] busy_res
  output logic [15:0]             m_axis_tdata,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CfgAddrWidth-1:0] paddr,
  input  logic [CfgDataWidth-1:0] pwdata,
  output logic [CfgDataWidth-1:0] prdata,
  output logic                    pready
);

  cfg_t    cfg;
  result_t res;
  result_t out_res;
  logic       in_valid;
  logic [1:0] in_opcode;
  logic       in_lock;
  logic       in_unlock;
  logic       advance;

  slseq_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // move the held item into the result register when that slot frees up
  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_opcode <= s_axis_tuser;
      in_lock   <= s_axis_tdata[0];
      in_unlock <= s_axis_tdata[1];
    end
  end

  slseq_fsm u_fsm (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .opcode        (in_opcode),
    .lock_sensor   (in_lock),
    .unlock_sensor (in_unlock),
    .cfg           (cfg),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = {{(16-ResultWidth){1'b0}}, out_res};

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the stow lock sequencer core.
module tb_top;
  import slseq_pkg::*;

  localparam logic [1:0] OP_NOP     = 2'd3;  // unused opcode, must leave state alone
  localparam int         CycleLimit = 400000;
  localparam int         DrainWait  = 6;

  logic                    clk           = 1'b0;
  logic                    rst           = 1'b1;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [7:0]              s_axis_tdata  = '0;   // [0] lock_sensor, [1] unlock_sensor
  logic [1:0]              s_axis_tuser  = '0;   // [1:0] opcode
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  // [0] lock_drive, [1] unlock_drive, [5:2] status_code, [6] done_pulse,
  // [7] fail_pulse, [8] busy_res
  logic [15:0]             m_axis_tdata;
  logic                    psel          = 1'b0;
  logic                    penable       = 1'b0;
  logic                    pwrite        = 1'b0;
  logic [CfgAddrWidth-1:0] paddr         = '0;
  logic [CfgDataWidth-1:0] pwdata        = '0;
  logic [CfgDataWidth-1:0] prdata;
  logic                    pready;

  stow_lock_sequencer_core dut (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Sequencer mirror: configuration and state as the block should hold them
  cfg_t                    seq_cfg;
  logic [2:0]              seq_phase;
  logic [1:0]              seq_pending;
  logic [ElapsedWidth-1:0] seq_elapsed;
  logic [StatusWidth-1:0]  seq_status;
  logic [1:0]              seq_drive;   // [0] lock, [1] unlock

  result_t sequencer_out_q[$];
  int      bad_results = 0;
  int      results_seen = 0;
  int      cycle_count = 0;

  bit src_idle_en  = 1'b0;
  bit sink_idle_en = 1'b0;
  int sink_hold_len = 0;
  int sink_hold_left = 0;
  int sink_gap_left = 0;

  function automatic logic [StatusWidth-1:0] status_for(input logic [StatusWidth-1:0] kind);
    return seq_cfg.axis_is_elevation ? kind + ElevOffset : kind;
  endfunction

  function automatic result_t step_sequencer(input logic [1:0] op, input logic lk,
                                             input logic ul);
    result_t                 r;
    logic                    is_lock;
    logic                    target;
    logic [ElapsedWidth:0]   sum;
    logic                    done;
    logic                    fail;
    done = 1'b0;
    fail = 1'b0;
    if (op == OP_LOCK || op == OP_UNLOCK) begin
      if (seq_phase == PH_IDLE) seq_pending = (op == OP_LOCK) ? REQ_LOCK : REQ_UNLOCK;
    end else if (op == OP_TICK) begin
      case (seq_phase)
        PH_IDLE: begin
          if (seq_pending == REQ_LOCK) begin
            seq_phase  = PH_LOCK_INIT;
            seq_status = status_for(ST_LOCKBUSY);
          end else if (seq_pending == REQ_UNLOCK) begin
            seq_phase  = PH_UNLOCK_INIT;
            seq_status = status_for(ST_UNLOCKBUSY);
          end
          seq_pending = REQ_NONE;
        end
        PH_LOCK_INIT, PH_UNLOCK_INIT: begin
          is_lock = (seq_phase == PH_LOCK_INIT);
          target  = is_lock ? lk : ul;
          if (lk && ul) begin
            seq_status = status_for(ST_ERROR);
            seq_phase  = PH_FAIL;
          end else if (target) begin
            seq_status = status_for(is_lock ? ST_LOCKED : ST_UNLOCKED);
            seq_phase  = is_lock ? PH_LOCK_DONE : PH_UNLOCK_DONE;
          end else begin
            seq_drive   = is_lock ? 2'b01 : 2'b10;
            seq_elapsed = '0;
            seq_status  = status_for(is_lock ? ST_LOCKBUSY : ST_UNLOCKBUSY);
            seq_phase   = is_lock ? PH_LOCKING : PH_UNLOCKING;
          end
        end
        PH_LOCKING, PH_UNLOCKING: begin
          is_lock = (seq_phase == PH_LOCKING);
          target  = is_lock ? lk : ul;
          sum = {1'b0, seq_elapsed} + (ElapsedWidth+1)'(seq_cfg.tick_period_ms);
          seq_elapsed = (sum > {1'b0, ElapsedMax}) ? ElapsedMax : sum[ElapsedWidth-1:0];
          if (target) begin
            seq_drive  = 2'b00;
            seq_status = status_for(is_lock ? ST_LOCKED : ST_UNLOCKED);
            seq_phase  = is_lock ? PH_LOCK_DONE : PH_UNLOCK_DONE;
          end else if (seq_elapsed > ElapsedWidth'(seq_cfg.time_limit_ms)) begin
            seq_drive  = 2'b00;
            seq_status = status_for(ST_ERROR);
            seq_phase  = PH_FAIL;
          end
        end
        PH_LOCK_DONE, PH_UNLOCK_DONE: begin
          done      = 1'b1;
          seq_phase = PH_IDLE;
        end
        default: begin
          fail      = 1'b1;
          seq_phase = PH_IDLE;
        end
      endcase
    end
    r.lock_drive   = seq_drive[0];
    r.unlock_drive = seq_drive[1];
    r.status_code  = seq_status;
    r.done_pulse   = done;
    r.fail_pulse   = fail;
    r.busy_res     = (seq_phase != PH_IDLE);
    return r;
  endfunction

  // Offer one item, hold it until taken, then record what it must produce
  task automatic send_item(input logic [1:0] op, input logic lk, input logic ul);
    int gap;
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {6'b0, ul, lk};
    do @(posedge clk); while (!s_axis_tready);
    sequencer_out_q.push_back(step_sequencer(op, lk, ul));
  endtask

  task automatic wait_outstanding();
    s_axis_tvalid <= 1'b0;
    while (sequencer_out_q.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CfgDataWidth-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_TICK_PERIOD: seq_cfg.tick_period_ms    = value[TickWidth-1:0];
      REG_TIMEOUT:     seq_cfg.time_limit_ms     = value[TimeoutWidth-1:0];
      REG_AXIS_ELEV:   seq_cfg.axis_is_elevation = value[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int tick, input int limit_ms, input bit elev);
    wait_outstanding();
    write_reg(REG_TICK_PERIOD, CfgDataWidth'(tick));
    write_reg(REG_TIMEOUT, CfgDataWidth'(limit_ms));
    write_reg(REG_AXIS_ELEV, CfgDataWidth'(elev));
  endtask

  // Pick the next item from the current phase: mostly well-formed lock and
  // unlock sequences, with some noise and requests that should be ignored.
  task automatic random_item(input int hit_pct, output bit counted);
    logic [1:0] op;
    logic       lk;
    logic       ul;
    logic       tgt_lock;
    int         roll;
    int         pick;
    roll = $urandom_range(0, 99);
    pick = $urandom_range(0, 99);
    op = OP_TICK;
    lk = 1'($urandom_range(0, 1));
    ul = 1'($urandom_range(0, 1));
    if (roll < 8) begin
      op = 2'($urandom_range(0, 3));
    end else begin
      case (seq_phase)
        PH_IDLE: begin
          if (seq_pending == REQ_NONE || roll < 25)
            op = $urandom_range(0, 1) ? OP_LOCK : OP_UNLOCK;
        end
        PH_LOCK_INIT, PH_UNLOCK_INIT, PH_LOCKING, PH_UNLOCKING: begin
          if (roll < 14) op = $urandom_range(0, 1) ? OP_LOCK : OP_UNLOCK;
          tgt_lock = (seq_phase == PH_LOCK_INIT || seq_phase == PH_LOCKING);
          if (seq_phase == PH_LOCK_INIT || seq_phase == PH_UNLOCK_INIT) hit_pct = 20;
          // keep the target sensor quiet most of the time so the drive runs on
          if (pick < 4) begin
            lk = 1'b1;
            ul = 1'b1;
          end else if (pick < 4 + hit_pct) begin
            lk = tgt_lock;
            ul = !tgt_lock;
          end else if (tgt_lock) begin
            lk = 1'b0;
          end else begin
            ul = 1'b0;
          end
        end
        default: begin
          if (roll < 14) op = $urandom_range(0, 1) ? OP_LOCK : OP_UNLOCK;
        end
      endcase
    end
    counted = !(op == OP_NOP || (op != OP_TICK && seq_phase != PH_IDLE));
    send_item(op, lk, ul);
  endtask

  task automatic test_random_settings(input int tick, input int limit_ms, input bit elev,
                                      input int n_items, input int hit_pct);
    int useful;
    bit counted;
    set_config(tick, limit_ms, elev);
    useful = 0;
    while (useful < n_items) begin
      random_item(hit_pct, counted);
      if (counted) useful++;
    end
  endtask

  // Reset settings: every opcode, request replacement, busy requests,
  // immediate completion, both sensors at start and while driving.
  task automatic test_directed_sequences();
    send_item(OP_TICK,   1'b0, 1'b0);
    send_item(OP_NOP,    1'b1, 1'b1);
    send_item(OP_LOCK,   1'b1, 1'b0);
    send_item(OP_UNLOCK, 1'b0, 1'b0);
    send_item(OP_TICK,   1'b0, 1'b0);
    send_item(OP_LOCK,   1'b0, 1'b0);
    send_item(OP_TICK,   1'b0, 1'b1);
    send_item(OP_TICK,   1'b0, 1'b0);
    send_item(OP_LOCK,   1'b0, 1'b1);
    send_item(OP_TICK,   1'b0, 1'b0);
    send_item(OP_TICK,   1'b1, 1'b1);
    send_item(OP_NOP,    1'b0, 1'b0);
    send_item(OP_TICK,   1'b0, 1'b0);
    send_item(OP_UNLOCK, 1'b1, 1'b1);
    send_item(OP_TICK,   1'b0, 1'b0);
    send_item(OP_TICK,   1'b0, 1'b0);
    send_item(OP_TICK,   1'b1, 1'b0);
    send_item(OP_TICK,   1'b1, 1'b1);
    send_item(OP_TICK,   1'b0, 1'b0);
    send_item(OP_LOCK,   1'b0, 1'b0);
    send_item(OP_TICK,   1'b0, 1'b0);
    send_item(OP_TICK,   1'b0, 1'b1);
    send_item(OP_TICK,   1'b1, 1'b0);
    send_item(OP_TICK,   1'b0, 1'b0);
  endtask

  // Short timeout on the elevation code set: drive runs out of time
  task automatic test_timeout_elevation();
    set_config(10, 20, 1'b1);
    send_item(OP_LOCK, 1'b0, 1'b0);
    repeat (5) send_item(OP_TICK, 1'b0, 1'b0);
    send_item(OP_TICK, 1'b0, 1'b1);
  endtask

  // Hold the result side off while items keep coming, so the input stalls
  task automatic test_backpressure();
    bit counted;
    set_config(10, 200, 1'b0);
    src_idle_en   = 1'b0;
    sink_hold_len = 300;
    repeat (40) random_item(10, counted);
    src_idle_en = 1'b1;
  endtask

  task automatic test_streaming_no_idle();
    set_config(25, 400, 1'b1);
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    test_random_settings(25, 400, 1'b1, 120, 6);
  endtask

  // Result side: random stall bursts plus an optional long hold
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b1;
    end else begin
      if (sink_hold_len > 0) begin
        sink_hold_left = sink_hold_len;
        sink_hold_len  = 0;
      end
      if (sink_hold_left > 0) begin
        sink_hold_left--;
        m_axis_tready <= 1'b0;
      end else if (sink_gap_left > 0) begin
        sink_gap_left--;
        m_axis_tready <= 1'b0;
      end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
        sink_gap_left = $urandom_range(1, 9) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  result_t got_res;
  result_t want_res;

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_res = result_t'(m_axis_tdata[ResultWidth-1:0]);
      if (sequencer_out_q.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("result %0d arrived with nothing expected: %b", results_seen, got_res);
      end else begin
        want_res = sequencer_out_q.pop_front();
        if (got_res.lock_drive   !== want_res.lock_drive   ||
            got_res.unlock_drive !== want_res.unlock_drive ||
            got_res.status_code  !== want_res.status_code  ||
            got_res.done_pulse   !== want_res.done_pulse   ||
            got_res.fail_pulse   !== want_res.fail_pulse   ||
            got_res.busy_res     !== want_res.busy_res) begin
          bad_results++;
          if (bad_results <= 10)
            $display({"result %0d mismatch: exp drv l%b u%b st %0d done %b fail %b busy %b",
                      " / got drv l%b u%b st %0d done %b fail %b busy %b"},
                     results_seen,
                     want_res.lock_drive, want_res.unlock_drive, want_res.status_code,
                     want_res.done_pulse, want_res.fail_pulse, want_res.busy_res,
                     got_res.lock_drive, got_res.unlock_drive, got_res.status_code,
                     got_res.done_pulse, got_res.fail_pulse, got_res.busy_res);
        end
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    seq_cfg     = '{TickPeriodReset, TimeoutReset, AxisElevReset};
    seq_phase   = PH_IDLE;
    seq_pending = REQ_NONE;
    seq_elapsed = '0;
    seq_status  = ST_NONE;
    seq_drive   = 2'b00;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_sequences();
    test_timeout_elevation();
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    test_random_settings(10, 5000, 1'b0, 250, 8);
    test_random_settings(1, 0, 1'b1, 250, 10);
    test_random_settings(0, 65535, 1'b0, 250, 8);
    test_random_settings(1023, 65535, 1'b1, 250, 2);
    test_backpressure();
    test_random_settings(1000, 3000, 1'b0, 250, 5);
    test_random_settings(7, 100, 1'b1, 250, 4);
    test_streaming_no_idle();

    wait_outstanding();
    if (bad_results == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/slseq_pkg.sv
design/slseq_cfg.sv
design/slseq_fsm.sv
design/stow_lock_sequencer_core.sv
dv/tb_top.sv
